// File: rtl/core/ibds_pkg.sv
// shared types, widths and the scl divider table for the divider search
package ibds_pkg;

    localparam int CLK_W      = 28;
    localparam int TGT_W      = 22;
    localparam int FIELD_W    = 24;
    localparam int SCL_W      = 12;
    localparam int MULT_IDX_W = 2;
    localparam int DIV_IDX_W  = 6;
    localparam int DIV_STEPS  = CLK_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(25000000);

    typedef struct packed {
        logic                  init;
        logic                  load;
        logic                  step;
        logic                  eval;
        logic [MULT_IDX_W-1:0] mult_idx;
        logic [DIV_IDX_W-1:0]  div_idx;
    } t_cmd;

    function automatic logic [SCL_W-1:0] scl_div(input logic [DIV_IDX_W-1:0] idx);
        logic [SCL_W-1:0] tbl [64];
        tbl = '{
            12'd20,   12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd34,   12'd40,
            12'd28,   12'd32,   12'd36,   12'd40,   12'd44,   12'd48,   12'd56,   12'd68,
            12'd48,   12'd56,   12'd64,   12'd72,   12'd80,   12'd88,   12'd104,  12'd128,
            12'd80,   12'd96,   12'd112,  12'd128,  12'd144,  12'd160,  12'd192,  12'd240,
            12'd160,  12'd192,  12'd224,  12'd256,  12'd288,  12'd320,  12'd384,  12'd480,
            12'd320,  12'd384,  12'd448,  12'd512,  12'd576,  12'd640,  12'd768,  12'd960,
            12'd640,  12'd768,  12'd896,  12'd1024, 12'd1152, 12'd1280, 12'd1536, 12'd1920,
            12'd1280, 12'd1536, 12'd1792, 12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd3840
        };
        return tbl[idx];
    endfunction

endpackage

// File: rtl/core/ibds_ctrl.sv
// sequencer: walks multiplier and divider indices and steps the divider
module ibds_ctrl
    import ibds_pkg::*;
#(
    parameter int MULT_CHOICES    = 3,
    parameter int DIVIDER_ENTRIES = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output logic o_done,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [MULT_IDX_W-1:0] MULT_LAST = MULT_IDX_W'(MULT_CHOICES - 1);
    localparam logic [DIV_IDX_W-1:0]  DIV_LAST  = DIV_IDX_W'(DIVIDER_ENTRIES - 1);
    localparam logic [STEP_W-1:0]     STEP_LAST = STEP_W'(DIV_STEPS - 1);

    logic [2:0]            r_state, n_state;
    logic [MULT_IDX_W-1:0] r_mult_idx, n_mult_idx;
    logic [DIV_IDX_W-1:0]  r_div_idx, n_div_idx;
    logic [STEP_W-1:0]     r_step, n_step;

    always_comb begin
        n_state    = r_state;
        n_mult_idx = r_mult_idx;
        n_div_idx  = r_div_idx;
        n_step     = r_step;
        o_cmd          = '0;
        o_cmd.mult_idx = r_mult_idx;
        o_cmd.div_idx  = r_div_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.init = 1'b1;
                    n_mult_idx = '0;
                    n_div_idx  = '0;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_step     = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_EVAL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (r_div_idx == DIV_LAST) begin
                    n_div_idx = '0;
                    if (r_mult_idx == MULT_LAST) begin
                        n_state = S_DONE;
                    end else begin
                        n_mult_idx = r_mult_idx + 1'b1;
                        n_state    = S_LOAD;
                    end
                end else begin
                    n_div_idx = r_div_idx + 1'b1;
                    n_state   = S_LOAD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mult_idx <= '0;
            r_div_idx  <= '0;
            r_step     <= '0;
        end else begin
            r_state    <= n_state;
            r_mult_idx <= n_mult_idx;
            r_div_idx  <= n_div_idx;
            r_step     <= n_step;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// File: rtl/core/ibds_dp.sv
// datapath: clock register, bit-serial divider and best-pair tracking
module ibds_dp
    import ibds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CLK_W-1:0]      i_cfg_wr_data,
    input  logic [TGT_W-1:0]      i_target_rate,
    input  t_cmd                  i_cmd,
    output logic [MULT_IDX_W-1:0] o_mult_code,
    output logic [DIV_IDX_W-1:0]  o_divider_code,
    output logic [FIELD_W-1:0]    o_achieved_rate,
    output logic [FIELD_W-1:0]    o_rate_error
);

    logic [CLK_W-1:0]      r_module_clock;
    logic [TGT_W-1:0]      r_target;
    logic [CLK_W-1:0]      r_quot;
    logic [SCL_W-1:0]      r_rem;
    logic [SCL_W-1:0]      r_divisor;
    logic                  r_found;
    logic [MULT_IDX_W-1:0] r_best_mult;
    logic [DIV_IDX_W-1:0]  r_best_div;
    logic [FIELD_W-1:0]    r_best_rate;
    logic [FIELD_W-1:0]    r_best_err;

    logic [SCL_W:0]     rem_sh;
    logic               fits;
    logic [SCL_W:0]     rem_sub;
    logic [FIELD_W-1:0] rate;
    logic [FIELD_W-1:0] tgt_ext;
    logic [FIELD_W-1:0] err;

    // restoring division, one quotient bit per beat
    assign rem_sh  = {r_rem, r_quot[CLK_W-1]};
    assign fits    = (rem_sh >= {1'b0, r_divisor});
    assign rem_sub = rem_sh - {1'b0, r_divisor};

    assign rate    = r_quot[FIELD_W-1:0];
    assign tgt_ext = FIELD_W'(r_target);
    assign err     = (tgt_ext >= rate) ? (tgt_ext - rate) : (rate - tgt_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_clock <= CLK_RESET;
        end else if (i_cfg_wr_en) begin
            r_module_clock <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.init) begin
            r_found <= 1'b0;
        end else if (i_cmd.eval) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_target <= i_target_rate;
        end
        if (i_cmd.load) begin
            // multiplier is a power of two: fold it in as a shift
            r_quot    <= r_module_clock >> i_cmd.mult_idx;
            r_rem     <= '0;
            r_divisor <= scl_div(i_cmd.div_idx);
        end else if (i_cmd.step) begin
            r_quot <= {r_quot[CLK_W-2:0], fits};
            r_rem  <= fits ? rem_sub[SCL_W-1:0] : rem_sh[SCL_W-1:0];
        end
        // strict compare keeps the first pair on a tie
        if (i_cmd.eval && (!r_found || err < r_best_err)) begin
            r_best_mult <= i_cmd.mult_idx;
            r_best_div  <= i_cmd.div_idx;
            r_best_rate <= rate;
            r_best_err  <= err;
        end
    end

    assign o_mult_code     = r_best_mult;
    assign o_divider_code  = r_best_div;
    assign o_achieved_rate = r_best_rate;
    assign o_rate_error    = r_best_err;

endmodule

// File: rtl/core/i2c_baud_divider_search.sv
// top level of the nearest bus clock divider search
// Pulse start while busy is low to search for the multiplier and scl divider pair whose
// rate module_clock/(mult*scl) lies closest to target_rate. The search walks
// MULT_CHOICES * DIVIDER_ENTRIES pairs, each a load, 28 steps of the one-bit-per-cycle
// divider and an evaluate. The result is shown for exactly one cycle with o_done high and
// cannot be stalled; the result ports hold it until the next search evaluates its first
// pair. Write module_clock through i_cfg_wr_en/i_cfg_wr_data only while busy is low.
module i2c_baud_divider_search
    import ibds_pkg::*;
#(
    parameter int MULT_CHOICES    = 3,
    parameter int DIVIDER_ENTRIES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CLK_W-1:0]      i_cfg_wr_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [TGT_W-1:0]      i_target_rate,
    output logic                  o_done,
    output logic [MULT_IDX_W-1:0] o_mult_code,
    output logic [DIV_IDX_W-1:0]  o_divider_code,
    output logic [FIELD_W-1:0]    o_achieved_rate,
    output logic [FIELD_W-1:0]    o_rate_error
);

    t_cmd cmd;

    ibds_ctrl #(
        .MULT_CHOICES    (MULT_CHOICES),
        .DIVIDER_ENTRIES (DIVIDER_ENTRIES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    ibds_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_target_rate   (i_target_rate),
        .i_cmd           (cmd),
        .o_mult_code     (o_mult_code),
        .o_divider_code  (o_divider_code),
        .o_achieved_rate (o_achieved_rate),
        .o_rate_error    (o_rate_error)
    );

endmodule
